// ===== hdl/scfu_pkg.sv =====
// scfu_pkg: shared types, codes and fixed-point helpers of the sparse coefficient
// frame unpacker. Used by the queue, front, back, top level and bench; depends on nothing.
`default_nettype none

package scfu_pkg;

  // frame marker byte
  localparam logic [7:0] FRAME_MARK = 8'd42;

  // entries of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // result kinds
  typedef enum logic [1:0] {
    KIND_COEF  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_CHANNEL_COUNT    = 2'd0,
    REG_BYTES_PER_SAMPLE = 2'd1,
    REG_VALUES_PER_FRAME = 2'd2,
    REG_BITMAP_BYTES     = 2'd3
  } reg_index_t;

  // clamped configuration
  typedef struct packed {
    logic [4:0]  nc;
    logic [2:0]  bps;
    logic [10:0] nv;
    logic [8:0]  bb;
  } cfg_t;

  // Q8.24 scales of the current frame
  typedef struct packed {
    logic [31:0] re;
    logic [31:0] im;
  } scales_t;

  // request from front to back
  typedef struct packed {
    kind_t       kind;
    logic [31:0] raw;
    logic        last;
  } entry_t;

  // saturate a sign and magnitude to signed 32 bits
  function automatic logic [31:0] sat_q(input logic neg, input logic [33:0] mag);
    logic [31:0] res;
    if (neg) begin
      res = (mag >= 34'h0_8000_0000) ? 32'h8000_0000 : 32'(34'd0 - mag);
    end else begin
      res = (mag > 34'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    end
    return res;
  endfunction

  // float32 to Q8.24, round half away from zero, saturating
  function automatic logic [31:0] float_to_q824(input logic [31:0] f);
    logic        neg;
    logic [7:0]  e;
    logic [7:0]  sh;
    logic [7:0]  n;
    logic [33:0] m;
    logic [33:0] mag;
    logic [31:0] res;
    neg = f[31];
    e   = f[30:23];
    m   = {10'd0, 1'b1, f[22:0]};
    sh  = e - 8'd126;
    n   = 8'd126 - e;
    mag = '0;
    if (e == 8'hFF) begin
      res = (f[22:0] != 23'd0) ? 32'd0 : sat_q(neg, 34'h0_FFFF_FFFF);
    end else if (e == 8'd0) begin
      res = 32'd0;
    end else if (e >= 8'd126) begin
      if (sh > 8'd9) begin
        res = sat_q(neg, 34'h0_FFFF_FFFF);
      end else begin
        mag = m << sh[3:0];
        res = sat_q(neg, mag);
      end
    end else begin
      if (n > 8'd25) begin
        mag = '0;
      end else begin
        mag = (m + (34'd1 << (n - 8'd1))) >> n;
      end
      res = sat_q(neg, mag);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/scfu_if.sv =====
// scfu_in_if and scfu_out_if: valid/ready channels of the unpacker.
// Stand-alone; no package needed.
`default_nettype none

interface scfu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink (input valid, input stream_byte, output ready);
endinterface

interface scfu_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         result_kind;
  logic signed [31:0] coeff_value;
  logic [9:0]         value_index;
  logic [2:0]         channel_number;
  logic               imag_part;
  logic               frame_last;

  modport source (output valid, output result_kind, output coeff_value, output value_index,
                  output channel_number, output imag_part, output frame_last, input ready);
  modport sink (input valid, input result_kind, input coeff_value, input value_index,
                input channel_number, input imag_part, input frame_last, output ready);
endinterface

`default_nettype wire

// ===== hdl/scfu_ram.sv =====
// scfu_ram: generic single write, single read memory with registered read data.
// No dependencies.
`default_nettype none

module scfu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/scfu_queue.sv =====
// scfu_queue: short request queue between the parser and the coefficient engine.
// Depends on scfu_pkg.
`default_nettype none

module scfu_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  scfu_pkg::entry_t     din,
  output logic                 full,
  input  wire logic            pop,
  output scfu_pkg::entry_t     dout,
  output logic                 empty
);

  localparam int PW = (scfu_pkg::QUEUE_DEPTH > 1) ? $clog2(scfu_pkg::QUEUE_DEPTH) : 1;

  scfu_pkg::entry_t slots [scfu_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [PW:0]   fill;

  assign full  = (fill == (PW+1)'(scfu_pkg::QUEUE_DEPTH));
  assign empty = (fill == '0);
  assign dout  = slots[rptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(scfu_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PW'(scfu_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= din;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/scfu_front.sv =====
// scfu_front: byte parser. Takes marker, scales, bitmaps and sample bytes, writes
// the presence memory and sends requests to the queue. Depends on scfu_pkg, scfu_if.
`default_nettype none

module scfu_front #(
  parameter int MAX_CHANNELS = 8,
  parameter int MAX_BITMAP_BYTES = 64,
  localparam int AW = (MAX_CHANNELS * MAX_BITMAP_BYTES > 1) ?
                      $clog2(MAX_CHANNELS * MAX_BITMAP_BYTES) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  scfu_in_if.sink            in_ch,
  input  scfu_pkg::cfg_t     cfg,
  input  wire logic          drained,
  output logic               push,
  output scfu_pkg::entry_t   push_data,
  input  wire logic          full,
  output scfu_pkg::scales_t  scales,
  output logic               ram_we,
  output logic [AW-1:0]      ram_waddr,
  output logic [7:0]         ram_wdata
);

  localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int OFF_W = (MAX_BITMAP_BYTES > 1) ? $clog2(MAX_BITMAP_BYTES) : 1;

  typedef enum logic [3:0] {
    F_MARKER  = 4'b0001,
    F_SCALE   = 4'b0010,
    F_BITMAP  = 4'b0100,
    F_SAMPLES = 4'b1000
  } fstate_t;

  fstate_t           state;
  logic [2:0]        hcnt;
  logic [23:0]       fasm;
  logic [CH_W-1:0]   ch;
  logic [OFF_W-1:0]  off;
  logic [13:0]       count;
  logic [13:0]       remaining;
  logic [31:0]       sasm;
  logic [1:0]        sbc;

  logic        accept;
  logic [7:0]  b;
  logic [4:0]  w;
  logic [13:0] total;
  logic        last_byte;
  logic [31:0] sasm_next;
  logic        sample_done;
  logic [31:0] raw;
  logic [31:0] conv;

  assign b      = in_ch.stream_byte;
  assign in_ch.ready = !full && ((state != F_MARKER) || drained);
  assign accept = in_ch.valid && in_ch.ready;

  // samples carried by one bitmap byte
  always_comb begin
    logic [10:0] pos;
    logic [11:0] two;
    w = '0;
    for (int k = 0; k < 8; k++) begin
      pos = {8'(off), 3'(k)};
      two = {pos, 1'b0};
      if (b[k] && (two < {1'b0, cfg.nv})) begin
        w = w + (((two + 12'd1) < {1'b0, cfg.nv}) ? 5'd2 : 5'd1);
      end
    end
  end

  assign total     = count + 14'(w);
  assign last_byte = (5'(ch) == cfg.nc - 5'd1) && (9'(off) == cfg.bb - 9'd1);

  // sample assembly and left justification
  assign sasm_next   = sasm | (32'(b) << {sbc, 3'b000});
  assign sample_done = ({1'b0, sbc} + 3'd1) == cfg.bps;
  assign raw         = sasm_next << (6'd32 - {cfg.bps, 3'b000});

  assign conv = scfu_pkg::float_to_q824({b, fasm});

  // presence memory write
  assign ram_we    = accept && (state == F_BITMAP);
  assign ram_waddr = AW'(ch * MAX_BITMAP_BYTES + off);
  assign ram_wdata = b;

  // requests to the queue
  always_comb begin
    push           = 1'b0;
    push_data.kind = scfu_pkg::KIND_COEF;
    push_data.raw  = raw;
    push_data.last = 1'b0;
    case (state)
      F_MARKER: begin
        if (accept && (b != scfu_pkg::FRAME_MARK)) begin
          push           = 1'b1;
          push_data.kind = scfu_pkg::KIND_ERROR;
          push_data.raw  = '0;
        end
      end
      F_BITMAP: begin
        if (accept && last_byte && (total == '0)) begin
          push           = 1'b1;
          push_data.kind = scfu_pkg::KIND_EMPTY;
          push_data.raw  = '0;
          push_data.last = 1'b1;
        end
      end
      F_SAMPLES: begin
        if (accept && sample_done) begin
          push           = 1'b1;
          push_data.last = (remaining == 14'd1);
        end
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= F_MARKER;
      hcnt      <= '0;
      fasm      <= '0;
      scales    <= '0;
      ch        <= '0;
      off       <= '0;
      count     <= '0;
      remaining <= '0;
      sasm      <= '0;
      sbc       <= '0;
    end else if (accept) begin
      case (state)
        F_MARKER: begin
          if (b == scfu_pkg::FRAME_MARK) begin
            state <= F_SCALE;
            hcnt  <= '0;
            fasm  <= '0;
          end
        end
        F_SCALE: begin
          case (hcnt[1:0])
            2'd0: fasm[7:0]   <= b;
            2'd1: fasm[15:8]  <= b;
            2'd2: fasm[23:16] <= b;
            default: begin
              fasm <= '0;
              if (hcnt[2]) begin
                scales.im <= conv;
              end else begin
                scales.re <= conv;
              end
            end
          endcase
          hcnt <= hcnt + 3'd1;
          if (hcnt == 3'd7) begin
            state <= F_BITMAP;
            ch    <= '0;
            off   <= '0;
            count <= '0;
          end
        end
        F_BITMAP: begin
          count <= total;
          if (9'(off) == cfg.bb - 9'd1) begin
            off <= '0;
            ch  <= ch + 1'b1;
          end else begin
            off <= off + 1'b1;
          end
          if (last_byte) begin
            sasm      <= '0;
            sbc       <= '0;
            remaining <= total;
            state     <= (total == '0) ? F_MARKER : F_SAMPLES;
          end
        end
        F_SAMPLES: begin
          if (sample_done) begin
            sasm      <= '0;
            sbc       <= '0;
            remaining <= remaining - 14'd1;
            if (remaining == 14'd1) begin
              state <= F_MARKER;
            end
          end else begin
            sasm <= sasm_next;
            sbc  <= sbc + 2'd1;
          end
        end
        default: begin
          state <= F_MARKER;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/scfu_back.sv =====
// scfu_back: coefficient engine. Seeks the next present sample in the presence
// memory, scales it and holds the result register. Depends on scfu_pkg, scfu_if.
`default_nettype none

module scfu_back #(
  parameter int MAX_CHANNELS = 8,
  parameter int MAX_BITMAP_BYTES = 64,
  localparam int AW = (MAX_CHANNELS * MAX_BITMAP_BYTES > 1) ?
                      $clog2(MAX_CHANNELS * MAX_BITMAP_BYTES) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  scfu_pkg::cfg_t     cfg,
  input  scfu_pkg::scales_t  scales,
  input  wire logic          q_empty,
  input  scfu_pkg::entry_t   q_data,
  output logic               q_pop,
  output logic               idle,
  output logic [AW-1:0]      ram_raddr,
  input  wire logic [7:0]    ram_rdata,
  scfu_out_if.source         out_ch
);

  localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  typedef enum logic [4:0] {
    B_IDLE  = 5'b00001,
    B_SEEK  = 5'b00010,
    B_CHECK = 5'b00100,
    B_MUL   = 5'b01000,
    B_OUT   = 5'b10000
  } bstate_t;

  bstate_t          state;
  scfu_pkg::entry_t ent;
  logic [9:0]       pos_i;
  logic [CH_W-1:0]  pos_ch;
  logic [9:0]       hit_i;
  logic [CH_W-1:0]  hit_ch;
  logic [63:0]      prod;

  logic               ov;
  scfu_pkg::kind_t    o_kind;
  logic signed [31:0] o_value;
  logic [9:0]         o_index;
  logic [2:0]         o_channel;
  logic               o_imag;
  logic               o_last;

  logic [5:0]  byte_sel;
  logic        in_map;
  logic        ch_wrap;
  logic [31:0] scale;
  logic [31:0] sm;
  logic [31:0] km;
  logic [63:0] rsum;
  logic [31:0] scaled;
  logic        load;

  assign idle     = (state == B_IDLE);
  assign q_pop    = (state == B_IDLE) && !q_empty;
  assign byte_sel = pos_i[9:4];
  assign in_map   = {3'd0, byte_sel} < cfg.bb;
  assign ch_wrap  = (5'(pos_ch) + 5'd1) >= cfg.nc;
  assign ram_raddr = AW'(pos_ch * MAX_BITMAP_BYTES + byte_sel);

  // sign and magnitude of sample and scale
  assign scale = hit_i[0] ? scales.im : scales.re;
  assign sm    = ent.raw[31] ? (32'd0 - ent.raw) : ent.raw;
  assign km    = scale[31] ? (32'd0 - scale) : scale;

  // rounding and saturation of the product
  assign rsum   = prod + 64'h4000_0000;
  assign scaled = scfu_pkg::sat_q(ent.raw[31] ^ scale[31], {1'b0, rsum[63:31]});

  assign load = (state == B_OUT) && (!ov || out_ch.ready);

  // seek, multiply and result sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= B_IDLE;
      pos_i  <= '0;
      pos_ch <= '0;
      hit_i  <= '0;
      hit_ch <= '0;
    end else begin
      case (state)
        B_IDLE: begin
          if (!q_empty) begin
            state <= (q_data.kind == scfu_pkg::KIND_COEF) ? B_SEEK : B_OUT;
          end
        end
        B_SEEK: begin
          if (in_map) begin
            state <= B_CHECK;
          end else if (ch_wrap) begin
            pos_ch <= '0;
            pos_i  <= pos_i + 10'd1;
          end else begin
            pos_ch <= pos_ch + 1'b1;
          end
        end
        B_CHECK: begin
          if (ram_rdata[pos_i[3:1]]) begin
            hit_i  <= pos_i;
            hit_ch <= pos_ch;
            state  <= B_MUL;
          end else begin
            state <= B_SEEK;
          end
          if (ch_wrap) begin
            pos_ch <= '0;
            pos_i  <= pos_i + 10'd1;
          end else begin
            pos_ch <= pos_ch + 1'b1;
          end
        end
        B_MUL: begin
          state <= B_OUT;
        end
        B_OUT: begin
          if (load) begin
            state <= B_IDLE;
            if (ent.last) begin
              pos_i  <= '0;
              pos_ch <= '0;
            end
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

  // request and product registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      ent <= q_data;
    end
    if (state == B_MUL) begin
      prod <= sm * km;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (load) begin
      ov <= 1'b1;
    end else if (out_ch.ready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      o_kind <= ent.kind;
      o_last <= ent.last;
      if (ent.kind == scfu_pkg::KIND_COEF) begin
        o_value   <= scaled;
        o_index   <= hit_i;
        o_channel <= 3'(hit_ch);
        o_imag    <= hit_i[0];
      end else begin
        o_value   <= '0;
        o_index   <= '0;
        o_channel <= '0;
        o_imag    <= 1'b0;
      end
    end
  end

  assign out_ch.valid          = ov;
  assign out_ch.result_kind    = o_kind;
  assign out_ch.coeff_value    = o_value;
  assign out_ch.value_index    = o_index;
  assign out_ch.channel_number = o_channel;
  assign out_ch.imag_part      = o_imag;
  assign out_ch.frame_last     = o_last;

  // the sample count of the frame guarantees a hit before the frame runs out
  a_seek_in_frame: assert property (@(posedge clk) disable iff (rst)
    (state == B_SEEK) |-> ({1'b0, pos_i} < cfg.nv))
    else $error("seek ran beyond the frame");

  // a popped request always goes to seek or straight to the result
  a_pop_next: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> ((state == B_SEEK) || (state == B_OUT)))
    else $error("popped request not taken up");

  // status results carry no coefficient
  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    (ov && (o_kind != scfu_pkg::KIND_COEF)) |-> ((o_value == '0) && (o_index == '0)))
    else $error("status result with coefficient data");

endmodule

`default_nettype wire

// ===== hdl/sparse_coefficient_frame_unpacker.sv =====
// Sparse coefficient frame unpacker. The parser takes header bytes (marker, two
// scales, bitmaps) and queues each completed sample. For each (value index,
// channel) position the seek visits, the coefficient engine reads the bitmap byte
// from the presence memory and checks the bit, and at a hit it scales the sample and
// registers the result; positions whose bitmap byte lies beyond the configured bitmap
// are skipped without a read. A short queue lets sample bytes keep coming while the
// seek runs. The next frame's marker byte, and each byte after a marker error, waits
// until queue and engine have drained, since scales and presence memory are reused.
// Depends on scfu_pkg, scfu_if, scfu_ram, scfu_queue, scfu_front and scfu_back.
`default_nettype none

module sparse_coefficient_frame_unpacker #(
  parameter int MAX_CHANNELS = 8,
  parameter int MAX_BITMAP_BYTES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  scfu_in_if.sink          in_ch,
  scfu_out_if.source       out_ch,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [10:0] cfg_data
);

  localparam int DEPTH = MAX_CHANNELS * MAX_BITMAP_BYTES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [3:0]  channel_count;
  logic [2:0]  bytes_per_sample;
  logic [10:0] values_per_frame;
  logic [6:0]  bitmap_bytes;

  scfu_pkg::cfg_t    cfg;
  scfu_pkg::scales_t scales;
  scfu_pkg::entry_t  push_data;
  scfu_pkg::entry_t  q_data;
  logic              push;
  logic              full;
  logic              q_pop;
  logic              q_empty;
  logic              back_idle;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [7:0]        ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [7:0]        ram_rdata;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count    <= 4'd1;
      bytes_per_sample <= 3'd2;
      values_per_frame <= 11'd1024;
      bitmap_bytes     <= 7'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        scfu_pkg::REG_CHANNEL_COUNT:    channel_count    <= cfg_data[3:0];
        scfu_pkg::REG_BYTES_PER_SAMPLE: bytes_per_sample <= cfg_data[2:0];
        scfu_pkg::REG_VALUES_PER_FRAME: values_per_frame <= cfg_data;
        scfu_pkg::REG_BITMAP_BYTES:     bitmap_bytes     <= cfg_data[6:0];
        default:                        channel_count    <= channel_count;
      endcase
    end
  end

  // clamp registers to their ranges
  always_comb begin
    cfg.nc = (channel_count == 4'd0) ? 5'd1 :
             ((5'(channel_count) > 5'(MAX_CHANNELS)) ? 5'(MAX_CHANNELS) : 5'(channel_count));
    cfg.bps = (bytes_per_sample == 3'd0) ? 3'd1 :
              ((bytes_per_sample > 3'd4) ? 3'd4 : bytes_per_sample);
    cfg.nv = (values_per_frame < 11'd2) ? 11'd2 :
             ((values_per_frame > 11'd1024) ? 11'd1024 : values_per_frame);
    cfg.bb = (bitmap_bytes == 7'd0) ? 9'd1 :
             ((9'(bitmap_bytes) > 9'(MAX_BITMAP_BYTES)) ? 9'(MAX_BITMAP_BYTES) :
              9'(bitmap_bytes));
  end

  scfu_front #(
    .MAX_CHANNELS    (MAX_CHANNELS),
    .MAX_BITMAP_BYTES(MAX_BITMAP_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .cfg      (cfg),
    .drained  (q_empty && back_idle),
    .push     (push),
    .push_data(push_data),
    .full     (full),
    .scales   (scales),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata)
  );

  scfu_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (push_data),
    .full (full),
    .pop  (q_pop),
    .dout (q_data),
    .empty(q_empty)
  );

  scfu_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_presence (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  scfu_back #(
    .MAX_CHANNELS    (MAX_CHANNELS),
    .MAX_BITMAP_BYTES(MAX_BITMAP_BYTES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .scales   (scales),
    .q_empty  (q_empty),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .idle     (back_idle),
    .ram_raddr(ram_raddr),
    .ram_rdata(ram_rdata),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

// ===== tb/sv/sparse_coefficient_frame_unpacker_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the sparse coefficient frame unpacker: frame streams, marker
// errors and empty frames over several register settings, checked by a local predictor.
// Depends on scfu_pkg, scfu_if and sparse_coefficient_frame_unpacker.

module sparse_coefficient_frame_unpacker_tb;

  localparam int N_MAP_CH    = 8;
  localparam int N_MAP_BYTES = 64;
  localparam int SETTLE      = 64;
  localparam int STALL_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;
  localparam int DIR_N       = 30;
  localparam int PHASE_BYTES = 40;

  typedef enum logic [3:0] {
    PH_MARK   = 4'b0001,
    PH_SCALES = 4'b0010,
    PH_MAP    = 4'b0100,
    PH_SAMP   = 4'b1000
  } parse_ph_t;

  typedef struct packed {
    scfu_pkg::kind_t kind;
    logic [31:0]     value;
    logic [9:0]      idx;
    logic [2:0]      ch;
    logic            imag;
    logic            last;
  } coeff_res_t;

  typedef struct {
    logic [7:0]      b;
    bit              typed;
    scfu_pkg::kind_t kind;
    logic            last;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [10:0] cfg_data;

  scfu_in_if  in_ch ();
  scfu_out_if out_ch ();

  sparse_coefficient_frame_unpacker dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // register copies and parser state of the predictor
  logic [3:0]  reg_nc;
  logic [2:0]  reg_bps;
  logic [10:0] reg_nv;
  logic [6:0]  reg_bb;
  parse_ph_t   ph;
  int unsigned hdr_cnt;
  logic [31:0] float_acc;
  logic [31:0] re_scale;
  logic [31:0] im_scale;
  logic [7:0]  presence [N_MAP_CH][N_MAP_BYTES];
  int unsigned pos_i;
  int unsigned pos_ch;
  logic [31:0] samp_acc;
  int unsigned samp_cnt;

  coeff_res_t pending_coeffs[$];
  int  mismatch_count;
  int  tx_idle_pct;
  int  rx_idle_pct;
  bit  hold_req;
  int  hold_left;
  int  quiet_cycles;
  int  n_bytes;

  // directed frames: nc 2, bps 1, nv 4, bb 1
  dir_row_t dir_tbl [DIR_N] = '{
    '{8'h00, 1'b1, scfu_pkg::KIND_ERROR, 1'b0}, '{8'hFF, 1'b1, scfu_pkg::KIND_ERROR, 1'b0},
    '{8'h2A, 1'b0, scfu_pkg::KIND_COEF, 1'b0},
    // real scale +inf, imag scale -256.0 (both saturate)
    '{8'h00, 1'b0, scfu_pkg::KIND_COEF, 1'b0}, '{8'h00, 1'b0, scfu_pkg::KIND_COEF, 1'b0},
    '{8'h80, 1'b0, scfu_pkg::KIND_COEF, 1'b0}, '{8'h7F, 1'b0, scfu_pkg::KIND_COEF, 1'b0},
    '{8'h00, 1'b0, scfu_pkg::KIND_COEF, 1'b0}, '{8'h00, 1'b0, scfu_pkg::KIND_COEF, 1'b0},
    '{8'h80, 1'b0, scfu_pkg::KIND_COEF, 1'b0}, '{8'hC3, 1'b0, scfu_pkg::KIND_COEF, 1'b0},
    '{8'h03, 1'b0, scfu_pkg::KIND_COEF, 1'b0}, '{8'h02, 1'b0, scfu_pkg::KIND_COEF, 1'b0},
    '{8'h7F, 1'b0, scfu_pkg::KIND_COEF, 1'b0}, '{8'h80, 1'b0, scfu_pkg::KIND_COEF, 1'b0},
    '{8'h00, 1'b0, scfu_pkg::KIND_COEF, 1'b0}, '{8'hFF, 1'b0, scfu_pkg::KIND_COEF, 1'b0},
    '{8'h01, 1'b0, scfu_pkg::KIND_COEF, 1'b0}, '{8'h80, 1'b0, scfu_pkg::KIND_COEF, 1'b0},
    // empty frame: scale 1.0, NaN, presence only beyond the frame length
    '{8'h2A, 1'b0, scfu_pkg::KIND_COEF, 1'b0},
    '{8'h00, 1'b0, scfu_pkg::KIND_COEF, 1'b0}, '{8'h00, 1'b0, scfu_pkg::KIND_COEF, 1'b0},
    '{8'h80, 1'b0, scfu_pkg::KIND_COEF, 1'b0}, '{8'h3F, 1'b0, scfu_pkg::KIND_COEF, 1'b0},
    '{8'h01, 1'b0, scfu_pkg::KIND_COEF, 1'b0}, '{8'h00, 1'b0, scfu_pkg::KIND_COEF, 1'b0},
    '{8'hC0, 1'b0, scfu_pkg::KIND_COEF, 1'b0}, '{8'h7F, 1'b0, scfu_pkg::KIND_COEF, 1'b0},
    '{8'h00, 1'b0, scfu_pkg::KIND_COEF, 1'b0}, '{8'hF0, 1'b1, scfu_pkg::KIND_EMPTY, 1'b1}
  };

  // clamped register values
  function automatic int unsigned eff_nc();
    return (reg_nc < 1) ? 1 : ((reg_nc > N_MAP_CH) ? N_MAP_CH : reg_nc);
  endfunction
  function automatic int unsigned eff_bps();
    return (reg_bps < 1) ? 1 : ((reg_bps > 4) ? 4 : reg_bps);
  endfunction
  function automatic int unsigned eff_nv();
    return (reg_nv < 2) ? 2 : ((reg_nv > 1024) ? 1024 : reg_nv);
  endfunction
  function automatic int unsigned eff_bb();
    return (reg_bb < 1) ? 1 : ((reg_bb > N_MAP_BYTES) ? N_MAP_BYTES : reg_bb);
  endfunction

  function automatic logic [31:0] sat32(input bit neg, input logic [63:0] mag);
    if (neg) return (mag >= 64'h8000_0000) ? 32'h8000_0000 : 32'(64'd0 - mag);
    return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
  endfunction

  // float32 bits to Q8.24, round half away from zero
  function automatic logic [31:0] float_q824(input logic [31:0] f);
    int unsigned e;
    logic [63:0] m;
    e = f[30:23];
    m = {40'd0, 1'b1, f[22:0]};
    if (e == 255) return (f[22:0] != 0) ? 32'd0 : sat32(f[31], 64'hFFFF_FFFF);
    if (e == 0) return 32'd0;
    if (e >= 126) begin
      if (e - 126 > 9) return sat32(f[31], 64'hFFFF_FFFF);
      return sat32(f[31], m << (e - 126));
    end
    if (126 - e > 25) return 32'd0;
    return sat32(f[31], (m + (64'd1 << (125 - e))) >> (126 - e));
  endfunction

  // Q1.31 sample times Q8.24 scale, back to Q8.24
  function automatic logic [31:0] scaled(input logic [31:0] raw, input logic [31:0] k);
    logic [63:0] sm;
    logic [63:0] km;
    sm = {32'd0, raw[31] ? 32'd0 - raw : raw};
    km = {32'd0, k[31] ? 32'd0 - k : k};
    return sat32(raw[31] ^ k[31], (sm * km + 64'h4000_0000) >> 31);
  endfunction

  function automatic bit is_present(input int unsigned i, input int unsigned ch);
    int unsigned bitn;
    bitn = i >> 1;
    if ((bitn >> 3) >= eff_bb() || ch >= N_MAP_CH) return 1'b0;
    return presence[ch][bitn >> 3][bitn & 7];
  endfunction

  // next present position at or after (i, ch)
  function automatic bit seek_next(input int unsigned i, input int unsigned ch);
    while (i < eff_nv()) begin
      while (ch < eff_nc()) begin
        if (is_present(i, ch)) begin
          pos_i  = i;
          pos_ch = ch;
          return 1'b1;
        end
        ch++;
      end
      ch = 0;
      i++;
    end
    return 1'b0;
  endfunction

  // advance the parser by one stream byte
  function automatic bit unpack_byte(input logic [7:0] b, output coeff_res_t r);
    int unsigned bb;
    r = '0;
    case (ph)
      PH_MARK: begin
        if (b != scfu_pkg::FRAME_MARK) begin
          r.kind = scfu_pkg::KIND_ERROR;
          return 1'b1;
        end
        ph = PH_SCALES;
        hdr_cnt = 0;
        float_acc = '0;
      end
      PH_SCALES: begin
        float_acc |= 32'(b) << (8 * (hdr_cnt & 3));
        if ((hdr_cnt & 3) == 3) begin
          if (hdr_cnt < 4) re_scale = float_q824(float_acc);
          else im_scale = float_q824(float_acc);
          float_acc = '0;
        end
        hdr_cnt++;
        if (hdr_cnt >= 8) begin
          ph = PH_MAP;
          hdr_cnt = 0;
        end
      end
      PH_MAP: begin
        bb = eff_bb();
        if (hdr_cnt / bb < N_MAP_CH) presence[hdr_cnt / bb][hdr_cnt % bb] = b;
        hdr_cnt++;
        if (hdr_cnt >= eff_nc() * bb) begin
          hdr_cnt = 0;
          samp_acc = '0;
          samp_cnt = 0;
          if (seek_next(0, 0)) begin
            ph = PH_SAMP;
          end else begin
            ph = PH_MARK;
            r.kind = scfu_pkg::KIND_EMPTY;
            r.last = 1'b1;
            return 1'b1;
          end
        end
      end
      default: begin
        samp_acc |= 32'(b) << (8 * (samp_cnt & 3));
        samp_cnt++;
        if (samp_cnt < eff_bps()) return 1'b0;
        r.kind  = scfu_pkg::KIND_COEF;
        r.value = scaled(samp_acc << (32 - 8 * eff_bps()), pos_i[0] ? im_scale : re_scale);
        r.idx   = pos_i[9:0];
        r.ch    = pos_ch[2:0];
        r.imag  = pos_i[0];
        samp_acc = '0;
        samp_cnt = 0;
        if (!seek_next(pos_i, pos_ch + 1)) begin
          ph = PH_MARK;
          pos_i = 0;
          pos_ch = 0;
          r.last = 1'b1;
        end
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    coeff_res_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_coeffs.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: kind %0d value %h", out_ch.result_kind,
                   out_ch.coeff_value);
      end else begin
        e = pending_coeffs.pop_front();
        if (out_ch.result_kind !== e.kind || out_ch.coeff_value !== e.value ||
            out_ch.value_index !== e.idx || out_ch.channel_number !== e.ch ||
            out_ch.imag_part !== e.imag || out_ch.frame_last !== e.last) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $write("mismatch: exp kind %0d val %h i %0d ch %0d im %0d last %0d",
                   e.kind, e.value, e.idx, e.ch, e.imag, e.last);
            $display(" / got kind %0d val %h i %0d ch %0d im %0d last %0d",
                     out_ch.result_kind, out_ch.coeff_value, out_ch.value_index,
                     out_ch.channel_number, out_ch.imag_part, out_ch.frame_last);
          end
        end
      end
    end
  end

  // watchdog on cycles with no request moving either way
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one byte, wait for its acceptance, then predict
  task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                           input coeff_res_t typed_res = '0);
    coeff_res_t r;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_ch.valid       <= 1'b1;
    in_ch.stream_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    n_bytes++;
    if (unpack_byte(b, r)) pending_coeffs.push_back(typed ? typed_res : r);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_coeffs.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input scfu_pkg::reg_index_t r, input logic [10:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    case (r)
      scfu_pkg::REG_CHANNEL_COUNT:    reg_nc  = v[3:0];
      scfu_pkg::REG_BYTES_PER_SAMPLE: reg_bps = v[2:0];
      scfu_pkg::REG_VALUES_PER_FRAME: reg_nv  = v;
      default:                        reg_bb  = v[6:0];
    endcase
  endtask

  task automatic configure(input logic [10:0] nc, input logic [10:0] bps,
                           input logic [10:0] nv, input logic [10:0] bb);
    cfg_write(scfu_pkg::REG_CHANNEL_COUNT, nc);
    cfg_write(scfu_pkg::REG_BYTES_PER_SAMPLE, bps);
    cfg_write(scfu_pkg::REG_VALUES_PER_FRAME, nv);
    cfg_write(scfu_pkg::REG_BITMAP_BYTES, bb);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] pick_scale();
    logic [31:0] f;
    f = $urandom();
    case ($urandom_range(7))
      0: ;
      6: case ($urandom_range(6))
           0: f = 32'h7F80_0000;
           1: f = 32'hFF80_0000;
           2: f = 32'h7FC0_0000;
           3: f = 32'h0000_0001;
           4: f = 32'h0000_0000;
           5: f = 32'h4380_0000;
           default: f = 32'hC37F_FFFF;
         endcase
      7: f[30:23] = 8'($urandom_range(126, 90));
      default: f[30:23] = 8'($urandom_range(135, 110));
    endcase
    return f;
  endfunction

  // one well-formed frame with random content, sometimes led by stray bytes
  task automatic send_frame(input int dens);
    logic [7:0]  map [N_MAP_CH][N_MAP_BYTES];
    logic [31:0] f;
    logic [7:0]  b;
    int unsigned n_samp;
    n_samp = 0;
    if ($urandom_range(99) < 8) begin
      repeat ($urandom_range(3, 1)) begin
        b = 8'($urandom());
        if (b == scfu_pkg::FRAME_MARK) b = ~b;
        send_byte(b);
      end
    end
    for (int ch = 0; ch < eff_nc(); ch++)
      for (int k = 0; k < eff_bb(); k++)
        for (int t = 0; t < 8; t++)
          map[ch][k][t] = ($urandom_range(99) < dens);
    for (int unsigned i = 0; i < eff_nv(); i++)
      for (int ch = 0; ch < eff_nc(); ch++)
        if (((i >> 1) >> 3) < eff_bb() && map[ch][(i >> 1) >> 3][(i >> 1) & 7]) n_samp++;
    send_byte(scfu_pkg::FRAME_MARK);
    repeat (2) begin
      f = pick_scale();
      for (int k = 0; k < 4; k++) send_byte(f[8 * k +: 8]);
    end
    for (int ch = 0; ch < eff_nc(); ch++)
      for (int k = 0; k < eff_bb(); k++) send_byte(map[ch][k]);
    repeat (n_samp * eff_bps()) begin
      case ($urandom_range(9))
        0: b = 8'h80;
        1: b = 8'h7F;
        2: b = 8'hFF;
        default: b = 8'($urandom());
      endcase
      send_byte(b);
    end
  endtask

  // register settings per phase, extremes and out-of-range values among them
  logic [10:0] set_nc  [8] = '{11'd2, 11'd0, 11'd8, 11'd15, 11'd3, 11'd5, 11'd4, 11'd1};
  logic [10:0] set_bps [8] = '{11'd1, 11'd4, 11'd3, 11'd7, 11'd0, 11'd2, 11'd2, 11'd3};
  logic [10:0] set_nv  [8] = '{11'd4, 11'd2, 11'd16, 11'd2047, 11'd6, 11'd40, 11'd64, 11'd1};
  logic [10:0] set_bb  [8] = '{11'd1, 11'd1, 11'd2, 11'd127, 11'd1, 11'd8, 11'd2, 11'd65};

  initial begin
    int sent;
    int dens;
    coeff_res_t tr;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.stream_byte = '0;
    out_ch.ready = 1'b0;
    hold_req = 1'b0;
    hold_left = 0;
    quiet_cycles = 0;
    mismatch_count = 0;
    n_bytes = 0;
    tx_idle_pct = 20;
    rx_idle_pct = 82;
    reg_nc = 4'd1;
    reg_bps = 3'd2;
    reg_nv = 11'd1024;
    reg_bb = 7'd64;
    ph = PH_MARK;
    hdr_cnt = 0;
    float_acc = '0;
    re_scale = '0;
    im_scale = '0;
    pos_i = 0;
    pos_ch = 0;
    samp_acc = '0;
    samp_cnt = 0;
    foreach (presence[c, k]) presence[c][k] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int p = 0; p < 8; p++) begin
      // idling profile: sender light / receiver heavy, then swapped, then none
      if (p == 3) begin
        tx_idle_pct = 82;
        rx_idle_pct = 20;
      end else if (p == 6) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      drain();
      configure(set_nc[p], set_bps[p], set_nv[p], set_bb[p]);
      if (p == 0) begin
        foreach (dir_tbl[r]) begin
          tr = '0;
          tr.kind = dir_tbl[r].kind;
          tr.last = dir_tbl[r].last;
          send_byte(dir_tbl[r].b, dir_tbl[r].typed, tr);
        end
      end else if (p == 3) begin
        send_frame(1);
      end else begin
        // in phase 2, a long receiver hold-off while bytes keep coming
        if (p == 2) hold_req = 1'b1;
        sent = n_bytes;
        while (n_bytes - sent < PHASE_BYTES) begin
          if ((p == 2) && (n_bytes == sent)) dens = 30;
          else if ($urandom_range(9) == 0) dens = 0;
          else dens = ($urandom_range(4) == 0) ? 100 : int'($urandom_range(30, 5));
          send_frame(dens);
        end
      end
    end

    drain();
    if (mismatch_count == 0 && pending_coeffs.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
